// ===== hw/rtl/ghash_pkg.sv =====
package ghash_pkg;

	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned LEN_W = 61;
	localparam int unsigned VB_W = 5;
	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned GF_BITS_PER_CYCLE = 8;
	localparam int unsigned GF_STEPS = BLOCK_W / GF_BITS_PER_CYCLE;
	localparam int unsigned GF_CNT_W = $clog2(GF_STEPS);
	localparam logic [BLOCK_W-1:0] REDUCE_TOP = {8'he1, 120'd0};

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic REG_SUBKEY_HIGH = 1'b0;
	localparam logic REG_SUBKEY_LOW = 1'b1;

	typedef struct packed {
		logic mode;
		logic [HALF_W-1:0] block_high;
		logic [HALF_W-1:0] block_low;
		logic [VB_W-1:0] valid_bytes;
		logic [LEN_W-1:0] aad_bytes;
		logic [LEN_W-1:0] text_bytes;
	} in_item_t;

	typedef struct packed {
		logic [HALF_W-1:0] hash_high;
		logic [HALF_W-1:0] hash_low;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gf_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/ghash_mul.sv =====
module ghash_mul
	import ghash_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [BLOCK_W-1:0] x,
	input  logic [BLOCK_W-1:0] h,
	output gf_sts_t sts,
	output logic [BLOCK_W-1:0] z
);

	logic [BLOCK_W-1:0] x_q;
	logic [BLOCK_W-1:0] v_q;
	logic [BLOCK_W-1:0] z_q;
	logic [GF_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [BLOCK_W-1:0] z_nxt;
	logic [BLOCK_W-1:0] v_nxt;

	// Eight multiply steps per cycle, most significant bit of the operand first.
	always_comb begin
		logic [BLOCK_W-1:0] zt;
		logic [BLOCK_W-1:0] vt;
		logic carry;
		zt = z_q;
		vt = v_q;
		for (int j = 0; j < GF_BITS_PER_CYCLE; j++) begin
			if (x_q[BLOCK_W-1-j]) begin
				zt = zt ^ vt;
			end
			carry = vt[0];
			vt = vt >> 1;
			if (carry) begin
				vt = vt ^ REDUCE_TOP;
			end
		end
		z_nxt = zt;
		v_nxt = vt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == GF_CNT_W'(GF_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			v_q <= h;
			z_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << GF_BITS_PER_CYCLE;
			v_q <= v_nxt;
			z_q <= z_nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign z = z_q;

endmodule

// ===== hw/rtl/ghash_accumulator_unit.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_item (in_item_t)
// out      output     out_valid/out_stall out_item (out_item_t)
// cfg      input      cfg_we              cfg_index, cfg_data
//
// An item that multiplies is accepted and starts the shared multiplier, which folds in
// eight bits of the operand per cycle; the item retires when the multiplier is done.
// An absorb item with no valid bytes is accepted and changes nothing.
// A finish item then loads the output register in the emit state, held there while stalled.
// Reset clears the subkey, the accumulator and all control state; no clearing pass.
module ghash_accumulator_unit
	import ghash_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_item,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [HALF_W-1:0] cfg_data
);

	state_t state_q;
	state_t state_nxt;
	logic [HALF_W-1:0] subkey_high_q;
	logic [HALF_W-1:0] subkey_low_q;
	logic [BLOCK_W-1:0] acc_q;
	logic mode_q;
	logic out_valid_q;
	out_item_t out_item_q;
	logic in_acc;
	logic mul_start;
	logic out_free;
	logic out_load;
	logic [BLOCK_W-1:0] mask;
	logic [BLOCK_W-1:0] mul_x;
	logic [BLOCK_W-1:0] mul_z;
	logic [VB_W-1:0] vb_sat;
	gf_sts_t mul_sts;

	ghash_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.x(mul_x),
		.h({subkey_high_q, subkey_low_q}),
		.sts(mul_sts),
		.z(mul_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkey_high_q <= '0;
			subkey_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUBKEY_HIGH: subkey_high_q <= cfg_data;
				REG_SUBKEY_LOW: subkey_low_q <= cfg_data;
				default: subkey_high_q <= subkey_high_q;
			endcase
		end
	end

	always_comb begin
		vb_sat = (in_item.valid_bytes > VB_W'(BLOCK_BYTES)) ? VB_W'(BLOCK_BYTES)
			: in_item.valid_bytes;
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			mask[BLOCK_W-1-j*BYTE_W -: BYTE_W] = (VB_W'(j) < vb_sat) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		if (in_item.mode == MODE_FINISH) begin
			mul_x = acc_q ^ {in_item.aad_bytes, 3'b000, in_item.text_bytes, 3'b000};
		end else begin
			mul_x = acc_q ^ ({in_item.block_high, in_item.block_low} & mask);
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign mul_start = in_acc && ((in_item.mode == MODE_FINISH) || (in_item.valid_bytes != '0));
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (mul_start) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_sts.done) begin
					state_nxt = (mode_q == MODE_FINISH) ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			mode_q <= MODE_ABSORB;
			out_valid_q <= 1'b0;
		end else begin
			if (mul_start) begin
				mode_q <= in_item.mode;
			end
			if (state_q == ST_MUL && mul_sts.done) begin
				acc_q <= (mode_q == MODE_FINISH) ? '0 : mul_z;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q.hash_high <= mul_z[BLOCK_W-1:HALF_W];
			out_item_q.hash_low <= mul_z[HALF_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

`ifndef SYNTH
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> state_q == ST_MUL)
		else $error("multiplier finished outside the multiply state");
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_EMIT)
		else $error("result shown without a finish item");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mul_sts.done && mode_q == MODE_FINISH) |=> acc_q == '0)
		else $error("accumulator not cleared after finish");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.busy |-> !mul_start)
		else $error("multiplier restarted while busy");
`endif

endmodule
